[rtl/core/bfdh_pkg.sv]
// bfdh_pkg: shared types and constants of the bloom filter double hashing unit
// no dependencies; imported by the remainder unit and the top level
`timescale 1ns / 1ps

package bfdh_pkg;

   // fixed field widths
   localparam int HASH_W = 32;
   localparam int SIZE_W = 17;
   localparam int PCNT_W = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_SIZE = 2'd1;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // remainder unit: quotient bits retired per cycle
   localparam int MOD_RADIX_BITS = 4;
   localparam int MOD_CYCLES     = HASH_W / MOD_RADIX_BITS;
   localparam int MOD_CNT_W      = $clog2(MOD_CYCLES);

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] remainder;
   } mod_rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_FINISH
   } state_type;

endpackage

[rtl/core/bfdh_mod_unit.sv]
// bfdh_mod_unit: iterative remainder of a 32-bit hash by the 17-bit filter size
// radix-16 restoring steps, one done pulse per request; uses bfdh_pkg
`timescale 1ns / 1ps

module bfdh_mod_unit
   import bfdh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   logic [HASH_W-1:0]    q_ff,   q_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    div_ff;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // four dependent compare-subtract steps per cycle
   always_comb begin
      logic [SIZE_W:0]   r;
      logic [SIZE_W-1:0] rem;
      logic [HASH_W-1:0] q;
      rem = rem_ff;
      q   = q_ff;
      for (int s = 0; s < MOD_RADIX_BITS; s++) begin
         r = {rem, q[HASH_W-1]};
         q = {q[HASH_W-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
         rem = r[SIZE_W-1:0];
      end
      q_in    = q;
      rem_in  = rem;
      cnt_in  = cnt_ff + MOD_CNT_W'(1);
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff && (cnt_ff == MOD_CNT_W'(MOD_CYCLES - 1))) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (mod_req.start || busy_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mod_req.start) begin
         q_ff   <= mod_req.dividend;
         rem_ff <= '0;
         div_ff <= mod_req.divisor;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

[rtl/core/bfdh_bit_ram.sv]
// bfdh_bit_ram: single-port one-bit-wide filter store, registered read
// no dependencies
`timescale 1ns / 1ps

module bfdh_bit_ram #(
   parameter int DEPTH  = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic              wr_data,
   output logic              rd_data
);

   logic mem_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bloom_filter_double_hashing_unit.sv]
// bloom_filter_double_hashing_unit: bloom filter bit store with enhanced double hashing
// depends on bfdh_pkg, bfdh_mod_unit and bfdh_bit_ram
//
// usage
//  - req channel (valid/stall): req_type (insert or query), req_hash_a, req_hash_b
//  - rsp channel (valid/stall): rsp_maybe_present, one transfer per query, none per insert
//  - csr channel (valid/ready, always ready): index 0 probe_count, 1 filter_size;
//    write only while the block is idle
//  - probe count P is 2 in plain mode (probe_count 0), else min(probe_count, MAX_PROBES)
//  - one item occupies the block, with req_stall high, until it leaves the finish
//    state: each probe waits on the remainder unit (4 quotient bits a cycle) plus one bit store access
//  - a query result reaches rsp_valid from the finish state through the output register
//  - after reset a clearing pass writes zero to each of the FILTER_BITS bits,
//    with req_stall high; csr writes are taken during it
//  - the result sits in an output register, so a stalled rsp side does not hold
//    off the next request; only a second query finishing waits for the register
`timescale 1ns / 1ps

module bloom_filter_double_hashing_unit
   import bfdh_pkg::*;
#(
   parameter int FILTER_BITS = 65536,
   parameter int MAX_PROBES  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [HASH_W-1:0]     req_hash_a,
   input  logic [HASH_W-1:0]     req_hash_b,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_maybe_present,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W    = $clog2(FILTER_BITS);
   localparam int TOTAL_MAX = (MAX_PROBES > 2) ? MAX_PROBES : 2;
   localparam int CNT_W     = $clog2(TOTAL_MAX + 1);

   // configuration registers
   logic [PCNT_W-1:0] probe_count_ff;
   logic [SIZE_W-1:0] filter_size_ff;

   // sequencer state
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [HASH_W-1:0] h_ff, h_in;       // current probe hash
   logic [HASH_W-1:0] d_ff, d_in;       // step to the next probe hash
   logic [CNT_W-1:0]  left_ff, left_in; // probes still to start
   logic              query_ff, query_in;
   logic              all_set_ff, all_set_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_maybe_ff, rsp_maybe_in;

   // derived settings
   logic [SIZE_W-1:0] active_size;
   logic [CNT_W-1:0]  active_probes;
   logic [HASH_W-1:0] h_next;
   logic              final_set;

   // bit store and remainder unit
   logic              ram_wr_en, ram_rd_en, ram_wr_data, ram_rd_data;
   logic [ADDR_W-1:0] ram_addr;
   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;

   bfdh_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   bfdh_bit_ram #(
      .DEPTH (FILTER_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // configuration writes, always accepted; unknown indices dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_count_ff <= '0;
         filter_size_ff <= SIZE_W'(65536);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PROBE_COUNT) begin
            probe_count_ff <= csr_wdata[PCNT_W-1:0];
         end else if (csr_index == CSR_FILTER_SIZE) begin
            filter_size_ff <= csr_wdata[SIZE_W-1:0];
         end
      end
   end

   // clamp size to 1 .. FILTER_BITS and probes to MAX_PROBES
   always_comb begin
      if (filter_size_ff == '0) begin
         active_size = SIZE_W'(1);
      end else if (32'(filter_size_ff) > FILTER_BITS) begin
         active_size = SIZE_W'(FILTER_BITS);
      end else begin
         active_size = filter_size_ff;
      end
      if (32'(probe_count_ff) > MAX_PROBES) begin
         active_probes = CNT_W'(MAX_PROBES);
      end else begin
         active_probes = CNT_W'(probe_count_ff);
      end
   end

   // next probe hash: h + d, d grows by 2 (i*b + i*i done incrementally)
   assign h_next    = h_ff + d_ff;
   // a read issued last cycle lands now
   assign final_set = all_set_ff & ~(rd_pend_ff & ~ram_rd_data);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      left_in      = left_ff;
      query_in     = query_ff;
      all_set_in   = final_set;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_maybe_in = rsp_maybe_ff;

      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_data  = 1'b0;
      ram_addr     = ADDR_W'(mod_rsp.remainder);

      mod_req.start    = 1'b0;
      mod_req.dividend = h_next;
      mod_req.divisor  = active_size;

      req_stall = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_addr  = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(FILTER_BITS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = req_hash_a;
               h_in             = req_hash_a;
               query_in         = (req_type == REQ_QUERY);
               all_set_in       = 1'b1;
               if (active_probes == '0) begin
                  // plain mode: second probe lands on hash_b
                  d_in    = req_hash_b - req_hash_a;
                  left_in = CNT_W'(1);
               end else begin
                  d_in    = req_hash_b + HASH_W'(1);
                  left_in = active_probes - CNT_W'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (mod_rsp.done) begin
               if (query_ff) begin
                  ram_rd_en  = 1'b1;
                  rd_pend_in = 1'b1;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = 1'b1;
               end
               if (left_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  left_in       = left_ff - CNT_W'(1);
                  h_in          = h_next;
                  d_in          = d_ff + HASH_W'(2);
                  mod_req.start = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!query_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_maybe_in = final_set;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and per-item registers
   always_ff @(posedge clock) begin
      h_ff         <= h_in;
      d_ff         <= d_in;
      left_ff      <= left_in;
      query_ff     <= query_in;
      all_set_ff   <= all_set_in;
      rsp_maybe_ff <= rsp_maybe_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_maybe_ff;

   // checks

   // a remainder handed over is always a valid store index
   a_rem_in_range : assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (mod_rsp.remainder < active_size))
      else $error("remainder not below filter size");

   // remainder results only arrive while probing
   a_done_in_probe : assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_PROBE))
      else $error("remainder done outside probe phase");

   // read data is only pending into probe or finish
   a_rd_pend_state : assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_PROBE || state_ff == ST_FINISH))
      else $error("store read pending in wrong state");

   // a query never writes the store, an insert never reads it
   a_no_rw_mix : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> !(ram_wr_en && query_ff) && !(ram_rd_en && !query_ff))
      else $error("store access does not match request kind");

endmodule
